### rtl/urtb_pkg.sv
`timescale 1ns / 1ps
// Package for the UART receive and transmit ring buffer engine.
// Holds request codes, field widths and default ring depths; depends on nothing.
package urtb_pkg;

  localparam int RX_DEPTH_DEF = 128;
  localparam int TX_DEPTH_DEF = 128;

  localparam int BYTE_W  = 8;
  localparam int COUNT_W = 7;
  localparam int BLEN_W  = 8;
  localparam int REQ_W   = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_LINE_BYTE  = 2'd0,
    REQ_HOST_READ  = 2'd1,
    REQ_HOST_WRITE = 2'd2,
    REQ_TX_READY   = 2'd3
  } req_t;

endpackage

### rtl/uart_rx_tx_ring_buffers.sv
`timescale 1ns / 1ps
// UART buffer engine with a receive ring and a transmit ring in two synchronous memories.
// Depends on urtb_pkg for request codes, widths and default depths.

// The block takes one item per clock cycle while in_stall is low and returns exactly
// one result item for each. The ring read that the item needs is registered at the
// accepting edge together with the item, and the output register is loaded from there
// when the item moves on. A stalled result holds the item behind it.
// Pointers, the idle flag and the burst check are updated at acceptance, so
// consecutive items see each other's effects without any gap. The receive ring never
// checks for overflow; host write bursts are refused whole when they do not fit in the
// transmit ring's free space (depth minus one). The configuration port is always ready.

module uart_rx_tx_ring_buffers #(
  parameter int RX_DEPTH = urtb_pkg::RX_DEPTH_DEF,
  parameter int TX_DEPTH = urtb_pkg::TX_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,

  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [urtb_pkg::REQ_W-1:0]    in_req_type,
  input  logic [urtb_pkg::BYTE_W-1:0]   in_line_byte,
  input  logic [urtb_pkg::BYTE_W-1:0]   in_host_data,
  input  logic                          in_burst_first,
  input  logic [urtb_pkg::BLEN_W-1:0]   in_burst_len,

  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [urtb_pkg::BYTE_W-1:0]   out_rx_data,
  output logic                          out_rx_valid,
  output logic                          out_write_accepted,
  output logic [urtb_pkg::BYTE_W-1:0]   out_tx_data,
  output logic                          out_tx_valid,
  output logic [urtb_pkg::COUNT_W-1:0]  out_rx_count,
  output logic [urtb_pkg::COUNT_W-1:0]  out_tx_space,
  output logic                          out_tx_idle,

  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_data
);

  localparam int RX_PW = $clog2(RX_DEPTH);
  localparam int RX_CW = RX_PW + 1;
  localparam int TX_PW = $clog2(TX_DEPTH);
  localparam int TX_CW = TX_PW + 1;
  localparam int CMP_W = 16;

  logic [urtb_pkg::BYTE_W-1:0] rx_mem [RX_DEPTH];
  logic [urtb_pkg::BYTE_W-1:0] tx_mem [TX_DEPTH];

  logic [RX_PW-1:0] rx_rd_ptr_r, rx_rd_ptr_nxt;
  logic [RX_PW-1:0] rx_wr_ptr_r, rx_wr_ptr_nxt;
  logic [TX_PW-1:0] tx_rd_ptr_r, tx_rd_ptr_nxt;
  logic [TX_PW-1:0] tx_wr_ptr_r, tx_wr_ptr_nxt;
  logic             tx_idle_r, tx_idle_nxt;
  logic             burst_ok_r, burst_ok_nxt;
  logic             rx_en_r;

  logic rx_mem_we, tx_mem_we, rx_mem_re, tx_mem_re;
  logic [urtb_pkg::BYTE_W-1:0] rx_rd_data_r, tx_rd_data_r;

  logic                         p_vld_r;
  logic                         p_rx_valid_r, p_rx_valid_nxt;
  logic                         p_acc_r, p_acc_nxt;
  logic                         p_tx_valid_r, p_tx_valid_nxt;
  logic [urtb_pkg::COUNT_W-1:0] p_rx_count_r, p_rx_count_nxt;
  logic [urtb_pkg::COUNT_W-1:0] p_tx_space_r, p_tx_space_nxt;

  logic                         out_vld_r;
  logic [urtb_pkg::BYTE_W-1:0]  out_rx_data_r;
  logic                         out_rx_valid_r;
  logic                         out_acc_r;
  logic [urtb_pkg::BYTE_W-1:0]  out_tx_data_r;
  logic                         out_tx_valid_r;
  logic [urtb_pkg::COUNT_W-1:0] out_rx_count_r;
  logic [urtb_pkg::COUNT_W-1:0] out_tx_space_r;
  logic                         out_tx_idle_r;
  logic                         p_tx_idle_r;

  logic                         in_acc, p_move;
  logic [TX_CW-1:0]             tx_free_cur;
  logic                         tx_can_write;

  function automatic logic [RX_CW-1:0] rx_used_f(logic [RX_PW-1:0] w, logic [RX_PW-1:0] r);
    logic [RX_CW-1:0] res;
    if (w >= r) begin
      res = {1'b0, w} - {1'b0, r};
    end else begin
      res = {1'b0, w} + RX_CW'(RX_DEPTH) - {1'b0, r};
    end
    return res;
  endfunction

  function automatic logic [TX_CW-1:0] tx_free_f(logic [TX_PW-1:0] w, logic [TX_PW-1:0] r);
    logic [TX_CW-1:0] used;
    if (w >= r) begin
      used = {1'b0, w} - {1'b0, r};
    end else begin
      used = {1'b0, w} + TX_CW'(TX_DEPTH) - {1'b0, r};
    end
    return TX_CW'(TX_DEPTH - 1) - used;
  endfunction

  function automatic logic [RX_PW-1:0] rx_inc_f(logic [RX_PW-1:0] p);
    return (p == RX_PW'(RX_DEPTH - 1)) ? '0 : p + RX_PW'(1);
  endfunction

  function automatic logic [TX_PW-1:0] tx_inc_f(logic [TX_PW-1:0] p);
    return (p == TX_PW'(TX_DEPTH - 1)) ? '0 : p + TX_PW'(1);
  endfunction

  assign p_move   = p_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = p_vld_r && !p_move;
  assign in_acc   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign tx_free_cur = tx_free_f(tx_wr_ptr_r, tx_rd_ptr_r);

  always_comb begin
    rx_rd_ptr_nxt  = rx_rd_ptr_r;
    rx_wr_ptr_nxt  = rx_wr_ptr_r;
    tx_rd_ptr_nxt  = tx_rd_ptr_r;
    tx_wr_ptr_nxt  = tx_wr_ptr_r;
    tx_idle_nxt    = tx_idle_r;
    burst_ok_nxt   = burst_ok_r;
    rx_mem_we      = 1'b0;
    tx_mem_we      = 1'b0;
    rx_mem_re      = 1'b0;
    tx_mem_re      = 1'b0;
    p_rx_valid_nxt = 1'b0;
    p_acc_nxt      = 1'b0;
    p_tx_valid_nxt = 1'b0;
    tx_can_write   = 1'b0;
    unique case (urtb_pkg::req_t'(in_req_type))
      urtb_pkg::REQ_LINE_BYTE: begin
        if (rx_en_r) begin
          rx_mem_we     = in_acc;
          rx_wr_ptr_nxt = rx_inc_f(rx_wr_ptr_r);
        end
      end
      urtb_pkg::REQ_HOST_READ: begin
        if (rx_rd_ptr_r != rx_wr_ptr_r) begin
          rx_mem_re      = in_acc;
          p_rx_valid_nxt = 1'b1;
          rx_rd_ptr_nxt  = rx_inc_f(rx_rd_ptr_r);
        end
      end
      urtb_pkg::REQ_HOST_WRITE: begin
        if (in_burst_first) begin
          burst_ok_nxt = (in_burst_len != '0) &&
                         (CMP_W'(in_burst_len) <= CMP_W'(tx_free_cur));
        end
        tx_can_write = burst_ok_nxt && (tx_free_cur != '0);
        if (tx_can_write) begin
          tx_mem_we     = in_acc;
          tx_wr_ptr_nxt = tx_inc_f(tx_wr_ptr_r);
          tx_idle_nxt   = 1'b0;
          p_acc_nxt     = 1'b1;
        end
      end
      urtb_pkg::REQ_TX_READY: begin
        if (tx_rd_ptr_r == tx_wr_ptr_r) begin
          tx_idle_nxt = 1'b1;
        end else begin
          tx_mem_re      = in_acc;
          p_tx_valid_nxt = 1'b1;
          tx_rd_ptr_nxt  = tx_inc_f(tx_rd_ptr_r);
        end
      end
      default: begin
      end
    endcase
    p_rx_count_nxt =
      (CMP_W'(rx_used_f(rx_wr_ptr_nxt, rx_rd_ptr_nxt)) > CMP_W'(127)) ?
      urtb_pkg::COUNT_W'(127) :
      urtb_pkg::COUNT_W'(rx_used_f(rx_wr_ptr_nxt, rx_rd_ptr_nxt));
    p_tx_space_nxt =
      (CMP_W'(tx_free_f(tx_wr_ptr_nxt, tx_rd_ptr_nxt)) > CMP_W'(127)) ?
      urtb_pkg::COUNT_W'(127) :
      urtb_pkg::COUNT_W'(tx_free_f(tx_wr_ptr_nxt, tx_rd_ptr_nxt));
  end

  always_ff @(posedge clk) begin
    if (rx_mem_we) begin
      rx_mem[rx_wr_ptr_r] <= in_line_byte;
    end
    if (rx_mem_re) begin
      rx_rd_data_r <= rx_mem[rx_rd_ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (tx_mem_we) begin
      tx_mem[tx_wr_ptr_r] <= in_host_data;
    end
    if (tx_mem_re) begin
      tx_rd_data_r <= tx_mem[tx_rd_ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_rd_ptr_r <= '0;
      rx_wr_ptr_r <= '0;
      tx_rd_ptr_r <= '0;
      tx_wr_ptr_r <= '0;
      tx_idle_r   <= 1'b0;
      burst_ok_r  <= 1'b0;
      rx_en_r     <= 1'b1;
      p_vld_r     <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        rx_en_r <= cfg_data;
      end
      if (in_acc) begin
        rx_rd_ptr_r <= rx_rd_ptr_nxt;
        rx_wr_ptr_r <= rx_wr_ptr_nxt;
        tx_rd_ptr_r <= tx_rd_ptr_nxt;
        tx_wr_ptr_r <= tx_wr_ptr_nxt;
        tx_idle_r   <= tx_idle_nxt;
        burst_ok_r  <= burst_ok_nxt;
        p_vld_r     <= 1'b1;
      end else if (p_move) begin
        p_vld_r <= 1'b0;
      end
      if (p_move) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      p_rx_valid_r <= p_rx_valid_nxt;
      p_acc_r      <= p_acc_nxt;
      p_tx_valid_r <= p_tx_valid_nxt;
      p_rx_count_r <= p_rx_count_nxt;
      p_tx_space_r <= p_tx_space_nxt;
      p_tx_idle_r  <= tx_idle_nxt;
    end
    if (p_move) begin
      out_rx_data_r  <= p_rx_valid_r ? rx_rd_data_r : '0;
      out_rx_valid_r <= p_rx_valid_r;
      out_acc_r      <= p_acc_r;
      out_tx_data_r  <= p_tx_valid_r ? tx_rd_data_r : '0;
      out_tx_valid_r <= p_tx_valid_r;
      out_rx_count_r <= p_rx_count_r;
      out_tx_space_r <= p_tx_space_r;
      out_tx_idle_r  <= p_tx_idle_r;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_rx_data        = out_rx_data_r;
  assign out_rx_valid       = out_rx_valid_r;
  assign out_write_accepted = out_acc_r;
  assign out_tx_data        = out_tx_data_r;
  assign out_tx_valid       = out_tx_valid_r;
  assign out_rx_count       = out_rx_count_r;
  assign out_tx_space       = out_tx_space_r;
  assign out_tx_idle        = out_tx_idle_r;

endmodule
